>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, quiet while rst_n is low
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: antecedent overlapped with consequent
`define CHK_IMPLY(lbl, ante, cons, msg) \
    `CHK_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> hw/rtl/ttlc_pkg.sv
// Shared types and constants of the TTL LRU cache table.
// No dependencies.
package ttlc_pkg;

    localparam int DEF_ENTRIES  = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 31;
    localparam int DEFAULT_TTL  = 60;

    localparam logic [6:0]  CAPACITY_RST = 7'd64;
    localparam logic [30:0] MIN_TTL_RST  = 31'd0;
    localparam logic [30:0] MAX_TTL_RST  = 31'd86400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY = 2'd0,
        REG_MIN_TTL  = 2'd1,
        REG_MAX_TTL  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_GET    = 2'd0,
        CMD_PUT    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [63:0]        domain_key;
        logic [15:0]        query_type;
        logic [31:0]        now_secs;
        logic [31:0]        value_in;
        logic signed [31:0] ttl_req;
        logic               has_answers;
        logic [30:0]        first_answer_ttl;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [31:0] remaining_secs;
        logic        evicted;
    } out_item_t;

    typedef struct packed {
        logic [63:0] domain;
        logic [15:0] qtype;
        logic [31:0] value;
        logic [31:0] expiry;
    } entry_pay_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_CLEAR,
        UPD_DROP,
        UPD_RECENT,
        UPD_INSERT
    } upd_mode_t;

endpackage

>>> hw/rtl/ttlc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ttlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/ttlc_expiry.sv
// TTL selection, clamping and saturating expiry for a put.
// Depends on ttlc_pkg.
module ttlc_expiry (
    input  logic               clk,
    input  ttlc_pkg::in_item_t item,
    input  logic [30:0]        min_ttl,
    input  logic [30:0]        max_ttl,
    output logic [31:0]        expiry
);
    import ttlc_pkg::*;

    logic [30:0] raw_ttl;
    logic [30:0] ttl_lim;
    logic [30:0] ttl_reg;
    logic [32:0] sum;
    logic [31:0] expiry_reg;

    // Pick the TTL source: override, first answer or default
    always_comb
    begin
        if (item.ttl_req[31])
        begin
            raw_ttl = item.has_answers ? item.first_answer_ttl : 31'(DEFAULT_TTL);
        end
        else
        begin
            raw_ttl = item.ttl_req[30:0];
        end
        if (raw_ttl < min_ttl)
        begin
            ttl_lim = min_ttl;
        end
        else if (raw_ttl > max_ttl)
        begin
            ttl_lim = max_ttl;
        end
        else
        begin
            ttl_lim = raw_ttl;
        end
    end

    // Add to the current time and saturate
    assign sum = {1'b0, item.now_secs} + {2'b00, ttl_reg};

    always_ff @(posedge clk)
    begin
        ttl_reg    <= ttl_lim;
        expiry_reg <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end

    assign expiry = expiry_reg;

endmodule

>>> hw/rtl/ttl_lru_cache_table.sv
// Top level of the TTL LRU cache table: sequencer, scan and update sweeps.
// Depends on ttlc_pkg, ttlc_ram and ttlc_expiry.
//
//  channel | signals                     | accepted when
//  input   | in_valid/in_ready/in_data   | in_valid & in_ready
//  output  | out_valid/out_ready/out_data| out_valid & out_ready
//  config  | cfg_we/cfg_idx/cfg_data     | cfg_we
//
// A get, put or remove runs one scan sweep, then the decide state and, when the table
// changes, one update sweep before out_valid rises; the sweeps are set by the one read
// and one write per cycle of the RAM. A clear runs the update sweep alone.
// The table returns to idle, where the next item is taken.
// After reset a clearing pass runs before in_ready rises.
// A stalled output holds its item; the next item may be taken meanwhile.
module ttl_lru_cache_table #(
    parameter int ENTRIES = ttlc_pkg::DEF_ENTRIES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ttlc_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ttlc_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [ttlc_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [ttlc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ttlc_pkg::*;

    localparam int RW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int PW = $bits(entry_pay_t);
    localparam int DW = 1 + RW + PW;

    state_t      state_reg, state_next;
    upd_mode_t   mode_reg, dec_mode;
    in_item_t    item_reg;
    logic        item_act_reg;
    logic [6:0]  cap_reg;
    logic [30:0] min_ttl_reg, max_ttl_reg;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] cap_eff;
    logic [RW:0]   cnt_reg;
    logic          p_vld_reg;
    logic [RW-1:0] p_idx_reg;
    logic          hit_reg;
    logic [RW-1:0] hit_idx_reg;
    logic [RW-1:0] hit_rank_reg;
    logic [31:0]   hit_val_reg;
    logic [31:0]   hit_exp_reg;
    logic          evict_reg;
    logic [RW-1:0] keep_lim_reg;
    logic          placed_reg;
    out_item_t     res_reg, res_dec;
    out_item_t     out_reg;
    logic          out_vld_reg;
    logic [31:0]   expiry;

    logic          rd_en, phase_done, wr_en;
    logic [DW-1:0] rd_word, wr_word;
    logic          e_valid, n_valid;
    logic [RW-1:0] e_rank, n_rank;
    entry_pay_t    e_pay, n_pay, put_pay;
    logic          e_match, e_evict, e_keep;

    ttlc_expiry u_expiry (
        .clk     (clk),
        .item    (item_reg),
        .min_ttl (min_ttl_reg),
        .max_ttl (max_ttl_reg),
        .expiry  (expiry)
    );

    ttlc_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (p_idx_reg),
        .wdata (wr_word),
        .re    (rd_en),
        .raddr (cnt_reg[RW-1:0]),
        .rdata (rd_word)
    );

    // Limit capacity into 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(cap_reg) > 32'(ENTRIES))
        begin
            cap_eff = CW'(ENTRIES);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    // Unpack the entry coming back from the RAM
    assign e_valid = rd_word[DW-1];
    assign e_rank  = rd_word[DW-2 -: RW];
    assign e_pay   = entry_pay_t'(rd_word[PW-1:0]);
    assign e_match = e_valid && (e_pay.domain == item_reg.domain_key)
                     && (e_pay.qtype == item_reg.query_type);
    assign put_pay = '{domain: item_reg.domain_key, qtype: item_reg.query_type,
                       value: item_reg.value_in, expiry: expiry};

    // Sweep sequencing
    assign rd_en      = ((state_reg == ST_SCAN) || (state_reg == ST_SWEEP))
                        && (cnt_reg < (RW+1)'(ENTRIES));
    assign phase_done = (cnt_reg == (RW+1)'(ENTRIES)) && !p_vld_reg;
    assign wr_en      = (state_reg == ST_SWEEP) && p_vld_reg;

    // Build the rewritten entry for the update sweep
    always_comb
    begin
        n_valid = e_valid;
        n_rank  = e_rank;
        n_pay   = e_pay;
        e_evict = e_valid && evict_reg && (e_rank >= keep_lim_reg);
        e_keep  = e_valid && !e_evict;
        case (mode_reg)
            UPD_CLEAR:
            begin
                n_valid = 1'b0;
            end
            UPD_DROP:
            begin
                if (p_idx_reg == hit_idx_reg)
                begin
                    n_valid = 1'b0;
                end
                else if (e_valid && (e_rank > hit_rank_reg))
                begin
                    n_rank = e_rank - RW'(1);
                end
            end
            UPD_RECENT:
            begin
                if (p_idx_reg == hit_idx_reg)
                begin
                    n_rank = '0;
                    if (item_reg.cmd == CMD_PUT)
                    begin
                        n_pay = put_pay;
                    end
                end
                else if (e_valid && (e_rank < hit_rank_reg))
                begin
                    n_rank = e_rank + RW'(1);
                end
            end
            UPD_INSERT:
            begin
                if (!e_keep && !placed_reg)
                begin
                    n_valid = 1'b1;
                    n_rank  = '0;
                    n_pay   = put_pay;
                end
                else if (e_keep)
                begin
                    n_rank = e_rank + RW'(1);
                end
                else
                begin
                    n_valid = 1'b0;
                end
            end
            default:
            begin
                n_valid = e_valid;
            end
        endcase
    end

    assign wr_word = {n_valid, n_rank, n_pay};

    // Decide the update and the result once the scan is done
    always_comb
    begin
        dec_mode = UPD_NONE;
        res_dec  = '0;
        case (cmd_t'(item_reg.cmd))
            CMD_GET:
            begin
                if (hit_reg && (hit_exp_reg <= item_reg.now_secs))
                begin
                    dec_mode = UPD_DROP;
                end
                else if (hit_reg)
                begin
                    dec_mode               = UPD_RECENT;
                    res_dec.found          = 1'b1;
                    res_dec.value_out      = hit_val_reg;
                    res_dec.remaining_secs = hit_exp_reg - item_reg.now_secs;
                end
            end
            CMD_PUT:
            begin
                if (hit_reg)
                begin
                    dec_mode = UPD_RECENT;
                end
                else
                begin
                    dec_mode        = UPD_INSERT;
                    res_dec.evicted = (occ_reg >= cap_eff);
                end
            end
            CMD_REMOVE:
            begin
                if (hit_reg)
                begin
                    dec_mode      = UPD_DROP;
                    res_dec.found = 1'b1;
                end
            end
            default:
            begin
                dec_mode = UPD_CLEAR;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.cmd == CMD_CLEAR) ? ST_SWEEP : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (phase_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = (dec_mode == UPD_NONE) ? ST_FINISH : ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (phase_done)
                begin
                    state_next = item_act_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = out_vld_reg;
        out_data  = out_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SWEEP;
            mode_reg     <= UPD_CLEAR;
            item_act_reg <= 1'b0;
            cnt_reg      <= '0;
            p_vld_reg    <= 1'b0;
            occ_reg      <= '0;
            out_vld_reg  <= 1'b0;
            cap_reg      <= CAPACITY_RST;
            min_ttl_reg  <= MIN_TTL_RST;
            max_ttl_reg  <= MAX_TTL_RST;
        end
        else
        begin
            state_reg <= state_next;
            p_vld_reg <= rd_en;

            // Take configuration writes
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_idx))
                    REG_CAPACITY: cap_reg     <= cfg_data[6:0];
                    REG_MIN_TTL:  min_ttl_reg <= cfg_data;
                    REG_MAX_TTL:  max_ttl_reg <= cfg_data;
                    default:      cap_reg     <= cap_reg;
                endcase
            end

            // Advance the sweep counter, restart it at each phase
            if ((state_reg == ST_IDLE) || (state_reg == ST_DECIDE))
            begin
                cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                cnt_reg <= cnt_reg + (RW+1)'(1);
            end

            if ((state_reg == ST_IDLE) && in_valid)
            begin
                item_act_reg <= 1'b1;
                mode_reg     <= UPD_CLEAR;
                if (in_data.cmd == CMD_CLEAR)
                begin
                    occ_reg <= '0;
                end
            end

            // Update occupancy with the chosen action
            if (state_reg == ST_DECIDE)
            begin
                mode_reg <= dec_mode;
                case (dec_mode)
                    UPD_DROP:
                    begin
                        if (occ_reg != '0)
                        begin
                            occ_reg <= occ_reg - CW'(1);
                        end
                    end
                    UPD_INSERT:
                    begin
                        if (occ_reg >= cap_eff)
                        begin
                            occ_reg <= cap_eff;
                        end
                        else
                        begin
                            occ_reg <= occ_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                        occ_reg <= occ_reg;
                    end
                endcase
            end

            // Load or drain the output register
            if ((state_reg == ST_FINISH) && (!out_vld_reg || out_ready))
            begin
                out_vld_reg  <= 1'b1;
                item_act_reg <= 1'b0;
            end
            else if (out_vld_reg && out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_idx_reg <= cnt_reg[RW-1:0];
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            item_reg <= in_data;
            hit_reg  <= 1'b0;
            res_reg  <= '0;
        end

        // Capture the first key match of the scan
        if ((state_reg == ST_SCAN) && p_vld_reg && e_match && !hit_reg)
        begin
            hit_reg      <= 1'b1;
            hit_idx_reg  <= p_idx_reg;
            hit_rank_reg <= e_rank;
            hit_val_reg  <= e_pay.value;
            hit_exp_reg  <= e_pay.expiry;
        end

        if (state_reg == ST_DECIDE)
        begin
            res_reg      <= res_dec;
            evict_reg    <= (occ_reg >= cap_eff);
            keep_lim_reg <= RW'(cap_eff - CW'(1));
            placed_reg   <= 1'b0;
        end

        // Mark the slot taken by an insert
        if (wr_en && (mode_reg == UPD_INSERT) && !e_keep)
        begin
            placed_reg <= 1'b1;
        end

        if ((state_reg == ST_FINISH) && (!out_vld_reg || out_ready))
        begin
            out_reg <= res_reg;
        end
    end

endmodule

>>> hw/rtl/ttlc_checker.sv
// Port-level checker of the TTL LRU cache table and its bind.
// Depends on ttlc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ttlc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input ttlc_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input ttlc_pkg::out_item_t out_data
);
    import ttlc_pkg::*;

    // Hold a stalled result item
    `CHK_ASSERT(a_out_hold,
        out_valid && !out_ready |=> out_valid && $stable(out_data),
        "out item dropped or changed while stalled")

    // One item in process: busy right after an accept
    `CHK_ASSERT(a_busy_after_accept,
        in_valid && in_ready |=> !in_ready,
        "item accepted while busy")

    // A miss carries no handle and no time
    `CHK_IMPLY(a_miss_zero,
        out_valid && !out_data.found,
        out_data.value_out == 32'd0 && out_data.remaining_secs == 32'd0,
        "miss item with nonzero fields")

    // Eviction only happens on a put that missed
    `CHK_IMPLY(a_evict_no_hit,
        out_valid && out_data.evicted,
        !out_data.found && out_data.remaining_secs == 32'd0,
        "eviction reported with a hit")

endmodule

bind ttl_lru_cache_table ttlc_checker u_ttlc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
